### hw/rtl/bw2d_pkg.sv
`default_nettype none
package bw2d_pkg;

    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_V0X = 3'd0,
        REG_V0Y = 3'd1,
        REG_V1X = 3'd2,
        REG_V1Y = 3'd3,
        REG_V2X = 3'd4,
        REG_V2Y = 3'd5
    } t_reg_idx;

endpackage
`default_nettype wire

### hw/rtl/bw2d_point_if.sv
`default_nettype none
interface bw2d_point_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

### hw/rtl/bw2d_weight_if.sv
`default_nettype none
interface bw2d_weight_if #(
    parameter int FRAC_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [FRAC_BITS+4:0]   weight0;
    logic signed [FRAC_BITS+4:0]   weight1;
    logic signed [FRAC_BITS+4:0]   weight2;
    logic                          degenerate;
    logic                          saturated;

    modport source (output valid, output weight0, output weight1, output weight2,
                    output degenerate, output saturated, input ready);
    modport sink   (input valid, input weight0, input weight1, input weight2,
                    input degenerate, input saturated, output ready);
endinterface
`default_nettype wire

### hw/rtl/barycentric_weights_2d.sv
// barycentric weights of a point against a triangle held in registers
//
// configuration: write port i_cfg_we / i_cfg_idx / i_cfg_data; index 0..5 are
// vertex0 x,y, vertex1 x,y, vertex2 x,y; other indexes are ignored. write only
// while no request is in flight and wait a few cycles before the next point.
// input channel i_pt carries point_x/point_y; output channel o_wt carries three
// signed weights with FRAC_BITS fraction bits, a degenerate and a saturated flag.
// throughput: one request per cycle while the receiver takes results. the
// pipeline is the divider, which resolves one quotient bit per pipeline stage,
// plus four stages of differences, products, numerators and dividend setup
// and an output register.
// the whole pipeline advances together; when the receiver holds ready low with
// a result waiting, every stage holds and i_pt.ready drops, nothing is lost.
// reset (synchronous, active low) clears all valid bits and sets all vertices
// to zero, which makes the triangle degenerate until it is written.
`default_nettype none
module barycentric_weights_2d #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [bw2d_pkg::REG_IDX_W-1:0]    i_cfg_idx,
    input  wire [COORD_BITS-1:0]             i_cfg_data,
    bw2d_point_if.sink                       i_pt,
    bw2d_weight_if.source                    o_wt
);
    import bw2d_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PW  = 2 * DW;
    localparam int AW  = PW + 1;
    localparam int W   = FRAC_BITS + 5;
    localparam int QB  = FRAC_BITS + 6;
    localparam int DVW = AW + FRAC_BITS + 1;
    localparam int TW  = DVW - QB;

    // configuration registers
    logic [C-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_V0X: r_cfg[REG_V0X] <= i_cfg_data;
                REG_V0Y: r_cfg[REG_V0Y] <= i_cfg_data;
                REG_V1X: r_cfg[REG_V1X] <= i_cfg_data;
                REG_V1Y: r_cfg[REG_V1Y] <= i_cfg_data;
                REG_V2X: r_cfg[REG_V2X] <= i_cfg_data;
                REG_V2Y: r_cfg[REG_V2Y] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] x0, y0, x1, y1, x2, y2, px, py;
    logic signed [DW-1:0] e10, e11, e20, e21;

    assign x0 = $signed({r_cfg[REG_V0X][C-1], r_cfg[REG_V0X]});
    assign y0 = $signed({r_cfg[REG_V0Y][C-1], r_cfg[REG_V0Y]});
    assign x1 = $signed({r_cfg[REG_V1X][C-1], r_cfg[REG_V1X]});
    assign y1 = $signed({r_cfg[REG_V1Y][C-1], r_cfg[REG_V1Y]});
    assign x2 = $signed({r_cfg[REG_V2X][C-1], r_cfg[REG_V2X]});
    assign y2 = $signed({r_cfg[REG_V2Y][C-1], r_cfg[REG_V2Y]});
    assign px = $signed({i_pt.point_x[C-1], i_pt.point_x});
    assign py = $signed({i_pt.point_y[C-1], i_pt.point_y});
    assign e10 = x1 - x0;
    assign e11 = y1 - y0;
    assign e20 = x2 - x0;
    assign e21 = y2 - y0;

    // twice the whole-triangle area, registered in r_cp0/r_cp1, r_whole, then r_ud/r_wneg/r_deg
    logic signed [PW-1:0] r_cp0, r_cp1;
    logic signed [AW-1:0] r_whole;
    logic [AW-1:0]        r_ud;
    logic                 r_wneg;
    logic                 r_deg;

    always_ff @(posedge i_clk) begin
        r_cp0   <= e10 * e21;
        r_cp1   <= e11 * e20;
        r_whole <= AW'(r_cp0) - AW'(r_cp1);
        r_wneg  <= r_whole[AW-1];
        r_ud    <= r_whole[AW-1] ? AW'(-r_whole) : AW'(r_whole);
        r_deg   <= (r_whole == '0);
    end

    // pipeline control
    localparam int NV = QB + 5;
    logic [NV-1:0] r_vld;
    logic          en;

    assign en         = !r_vld[NV-1] || o_wt.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_pt.valid};
        end
    end

    // stage a: differences
    logic signed [DW-1:0] r_a0, r_b0, r_c0, r_d0, r_a1, r_a2;
    // stage b: products
    logic signed [PW-1:0] r_p [6];
    // stage c: numerators
    logic signed [AW-1:0] r_num [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= x1 - px;
            r_b0 <= y2 - py;
            r_c0 <= y1 - py;
            r_d0 <= x2 - px;
            r_a1 <= px - x0;
            r_a2 <= py - y0;
            r_p[0] <= r_a0 * r_b0;
            r_p[1] <= r_c0 * r_d0;
            r_p[2] <= r_a1 * e21;
            r_p[3] <= r_a2 * e20;
            r_p[4] <= e10 * r_a2;
            r_p[5] <= e11 * r_a1;
            r_num[0] <= AW'(r_p[0]) - AW'(r_p[1]);
            r_num[1] <= AW'(r_p[2]) - AW'(r_p[3]);
            r_num[2] <= AW'(r_p[4]) - AW'(r_p[5]);
        end
    end

    // divider: one quotient bit per stage, per lane
    logic [AW-1:0] r_rem [3][QB+1];
    logic [QB-1:0] r_low [3][QB+1];
    logic [QB-1:0] r_q   [3][QB+1];
    logic          r_neg [3][QB+1];
    logic          r_ovf [3][QB+1];

    logic signed [W-1:0] n_w [3];
    logic [2:0]          n_sat;

    localparam logic [QB-1:0] MAXP = QB'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [QB-1:0] MAXN = QB'(64'd1 << (W - 1));

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [AW-1:0]  un;
        logic [DVW-1:0] dvd;
        logic [TW-1:0]  top;

        always_comb begin
            un  = r_num[l][AW-1] ? AW'(-r_num[l]) : AW'(r_num[l]);
            dvd = {1'b0, un, FRAC_BITS'(0)} + DVW'(r_ud >> 1);
            top = dvd[DVW-1:QB];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[l][0] <= AW'(top);
                r_low[l][0] <= dvd[QB-1:0];
                r_q[l][0]   <= '0;
                r_neg[l][0] <= r_num[l][AW-1] ^ r_wneg;
                r_ovf[l][0] <= (AW'(top) >= r_ud);
            end
        end

        for (genvar k = 1; k <= QB; k++) begin : g_step
            logic [AW:0] sh;
            logic        ge;
            logic [AW:0] df;

            always_comb begin
                sh = {r_rem[l][k-1], r_low[l][k-1][QB-1]};
                ge = (sh >= {1'b0, r_ud});
                df = sh - {1'b0, r_ud};
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[l][k] <= ge ? df[AW-1:0] : sh[AW-1:0];
                    r_low[l][k] <= {r_low[l][k-1][QB-2:0], 1'b0};
                    r_q[l][k]   <= {r_q[l][k-1][QB-2:0], ge};
                    r_neg[l][k] <= r_neg[l][k-1];
                    r_ovf[l][k] <= r_ovf[l][k-1];
                end
            end
        end

        // rounding is in the dividend; here only clamp and sign
        always_comb begin
            logic [QB-1:0] q;
            logic          ng;
            q  = r_q[l][QB];
            ng = r_neg[l][QB];
            n_sat[l] = 1'b0;
            n_w[l]   = '0;
            if (ng) begin
                if (r_ovf[l][QB] || q > MAXN) begin
                    n_sat[l] = 1'b1;
                    n_w[l]   = $signed(W'(MAXN));
                end else begin
                    n_w[l] = $signed(W'(-q));
                end
            end else begin
                if (r_ovf[l][QB] || q > MAXP) begin
                    n_sat[l] = 1'b1;
                    n_w[l]   = $signed(W'(MAXP));
                end else begin
                    n_w[l] = $signed(W'(q));
                end
            end
        end
    end

    // output register
    logic signed [W-1:0] r_w [3];
    logic                r_odeg;
    logic                r_osat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) r_w[l] <= r_deg ? '0 : n_w[l];
            r_odeg <= r_deg;
            r_osat <= !r_deg && (|n_sat);
        end
    end

    assign o_wt.valid      = r_vld[NV-1];
    assign o_wt.weight0    = r_w[0];
    assign o_wt.weight1    = r_w[1];
    assign o_wt.weight2    = r_w[2];
    assign o_wt.degenerate = r_odeg;
    assign o_wt.saturated  = r_osat;

    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wt.valid && o_wt.degenerate |->
            o_wt.weight0 == '0 && o_wt.weight1 == '0 && o_wt.weight2 == '0 &&
            !o_wt.saturated)
        else $error("degenerate result with nonzero weights");

    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready == (!o_wt.valid || o_wt.ready))
        else $error("input ready does not follow output stall");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import bw2d_pkg::*;

    localparam int CB = 12;
    localparam int FB = 16;
    localparam int WB = FB + 5;
    localparam int LATENCY = FB + 10;

    typedef struct packed {
        logic [WB-1:0] w0;
        logic [WB-1:0] w1;
        logic [WB-1:0] w2;
        logic          degen;
        logic          sat;
    } t_weights;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [CB-1:0] i_cfg_data;

    bw2d_point_if  #(.COORD_BITS(CB)) pt_if ();
    bw2d_weight_if #(.FRAC_BITS(FB))  wt_if ();

    barycentric_weights_2d #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt(pt_if.sink), .o_wt(wt_if.source)
    );

    // triangle as the block should hold it
    logic signed [CB-1:0] tri_v [NUM_REGS];
    t_weights expected_weights [$];
    int  mismatches;
    int  results_seen;
    int  saturated_seen;
    int  degenerate_seen;
    int  stall_left;
    bit  idle_bursts;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    function automatic longint shoelace(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
        return (bx - ax) * (by + ay) + (cx - bx) * (cy + by) + (ax - cx) * (ay + cy);
    endfunction

    function automatic logic [WB-1:0] scale_weight(longint num, longint den,
                                                   inout logic sat);
        bit      neg;
        longint  un, ud, q;
        longint  max_pos, max_neg;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = ((un <<< FB) + ud / 2) / ud;
        max_pos = (longint'(1) <<< (WB - 1)) - 1;
        max_neg = longint'(1) <<< (WB - 1);
        if (!neg) begin
            if (q > max_pos) begin
                q = max_pos;
                sat = 1'b1;
            end
            return q[WB-1:0];
        end
        if (q > max_neg) begin
            q = max_neg;
            sat = 1'b1;
        end
        q = -q;
        return q[WB-1:0];
    endfunction

    function automatic t_weights predict_weights(logic [CB-1:0] px, logic [CB-1:0] py);
        t_weights r;
        longint   x0, y0, x1, y1, x2, y2, qx, qy, whole;
        logic     sat;
        x0 = tri_v[REG_V0X]; y0 = tri_v[REG_V0Y];
        x1 = tri_v[REG_V1X]; y1 = tri_v[REG_V1Y];
        x2 = tri_v[REG_V2X]; y2 = tri_v[REG_V2Y];
        qx = $signed(px);
        qy = $signed(py);
        whole = shoelace(x0, y0, x1, y1, x2, y2);
        r = '0;
        sat = 1'b0;
        if (whole == 0) begin
            r.degen = 1'b1;
            return r;
        end
        r.w0 = scale_weight(shoelace(qx, qy, x1, y1, x2, y2), whole, sat);
        r.w1 = scale_weight(shoelace(x0, y0, qx, qy, x2, y2), whole, sat);
        r.w2 = scale_weight(shoelace(x0, y0, x1, y1, qx, qy), whole, sat);
        r.sat = sat;
        return r;
    endfunction

    // write enable stays high across back-to-back writes, caller drops it
    task automatic write_reg(t_reg_idx idx, logic [CB-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        tri_v[idx] = val;
    endtask

    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        while (expected_weights.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic load_triangle(logic [CB-1:0] ax, logic [CB-1:0] ay, logic [CB-1:0] bx,
                                 logic [CB-1:0] by, logic [CB-1:0] cx, logic [CB-1:0] cy);
        wait_drained();
        write_reg(REG_V0X, ax);
        write_reg(REG_V0Y, ay);
        write_reg(REG_V1X, bx);
        write_reg(REG_V1Y, by);
        write_reg(REG_V2X, cx);
        write_reg(REG_V2Y, cy);
        i_cfg_we <= 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    // called at a falling edge, returns at a falling edge after acceptance with valid
    // still high; the next send keeps or drops it, a drain takes it down
    task automatic send_point(logic [CB-1:0] px, logic [CB-1:0] py);
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= px;
        pt_if.point_y <= py;
        do @(posedge i_clk); while (!pt_if.ready);
        expected_weights.push_back(predict_weights(px, py));
        @(negedge i_clk);
    endtask

    task automatic test_reset_triangle();
        send_point(12'sd5, -12'sd7);
        send_point(12'h7ff, 12'h800);
    endtask

    task automatic test_directed_points();
        logic [CB-1:0] ext [4] = '{12'h800, 12'h7ff, 12'h000, 12'hfff};
        load_triangle(12'd0, 12'd0, 12'd100, 12'd0, 12'd0, 12'd100);
        foreach (ext[i]) foreach (ext[j]) send_point(ext[i], ext[j]);
        send_point(12'd0, 12'd0);
        send_point(12'd100, 12'd0);
        send_point(12'd33, 12'd33);
        // rounding of thirds: triangle with doubled area 3
        load_triangle(12'd0, 12'd0, 12'd3, 12'd0, 12'd0, 12'd1);
        send_point(12'd1, 12'd0);
        send_point(12'h7ff, 12'h7ff);
        // extreme vertices, clockwise
        load_triangle(12'h800, 12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h800);
        send_point(12'h7ff, 12'h7ff);
        send_point(12'h000, 12'h000);
        // collinear, nonzero coords
        load_triangle(12'd1, 12'd1, 12'd2, 12'd2, 12'd3, 12'd3);
        send_point(12'd9, 12'h800);
    endtask

    task automatic test_random_points(int rounds, int per_round);
        for (int r = 0; r < rounds; r++) begin
            logic [CB-1:0] v [6];
            foreach (v[k]) v[k] = CB'($urandom);
            // small triangles make saturation common, collinear ones degenerate
            if (r % 4 == 1) foreach (v[k]) v[k] = CB'($urandom_range(0, 8) - 4);
            if (r % 9 == 5) begin
                v[4] = v[2];
                v[5] = v[3];
            end
            load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
            for (int n = 0; n < per_round; n++) begin
                if ($urandom_range(0, 1))
                    send_point(CB'($urandom), CB'($urandom));
                else
                    send_point(CB'(v[$urandom_range(0, 2) * 2] + $urandom_range(0, 40) - 20),
                               CB'(v[$urandom_range(0, 2) * 2 + 1] +
                                   $urandom_range(0, 40) - 20));
            end
        end
    endtask

    // sampled at the rising edge, ready changed at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && wt_if.valid && wt_if.ready) begin
            t_weights got, exp_w;
            got = '{wt_if.weight0, wt_if.weight1, wt_if.weight2,
                    wt_if.degenerate, wt_if.saturated};
            results_seen++;
            if (expected_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_w = expected_weights.pop_front();
                saturated_seen += exp_w.sat;
                degenerate_seen += exp_w.degen;
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_w, got);
                end
            end
        end
    end

    // receiver stalls come in bursts of random length while idle_bursts is set
    always @(negedge i_clk) begin
        if (!idle_bursts) begin
            stall_left = 0;
            wt_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) wt_if.ready <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
            wt_if.ready <= 1'b0;
        end
    end

    initial begin
        mismatches = 0;
        results_seen = 0;
        saturated_seen = 0;
        degenerate_seen = 0;
        stall_left = 0;
        idle_bursts = 1'b1;
        foreach (tri_v[k]) tri_v[k] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_V0X;
        i_cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        wt_if.ready = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_triangle();
        test_directed_points();
        test_random_points(30, 40);
        // hold off until the pipeline has drained, then continue at full rate
        wait_drained();
        idle_bursts = 1'b0;
        test_random_points(4, 50);
        wait_drained();
        $display("checked %0d results across many triangles, %0d saturated, %0d degenerate",
                 results_seen, saturated_seen, degenerate_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
